@@ src/ghbs_pkg.sv @@
// Shared types, constants and helpers for the grid height bilinear sampler.
// No dependencies; imported by every module of the block but ghbs_ram.
package ghbs_pkg;

   // Defaults for the grid size parameters.
   localparam int DEF_MAX_X_VERTICES = 64;
   localparam int DEF_MAX_Z_VERTICES = 64;

   // Fixed field widths.
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 2;
   localparam int VIDX_W    = 12;
   localparam int SAMPLE_W  = 8;
   localparam int COORD_W   = 16;
   localparam int HEIGHT_W  = 16;

   // Fixed-point datapath widths.
   localparam int MUL_A_W = 24;   // widest A operand: Q8.15 row blend
   localparam int MUL_B_W = 16;   // Q0.15 weights up to 1.0, offsets up to 32768
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 39;   // Q8.30 column blend
   localparam int S_W     = 23;   // (n-1)*u, cell in [22:15], fraction in [14:0]
   localparam int FRAC_W  = 15;
   localparam int CELL_W  = S_W - FRAC_W;
   localparam int ROW_W   = 23;   // Q8.15 row blend
   localparam int CLAMP_W = COORD_W + 1;
   localparam int IDX_X_W = 17;   // wide enough for any store address sum

   localparam logic [MUL_B_W-1:0] ONE_Q15 = 16'h8000;
   localparam int COUNT_RESET = 64;
   localparam int ROUND_SHIFT = 22;

   // Operation codes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // CSR indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_X_VERTICES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_VERTICES = 2'd1;

   // Corner select: bit 0 picks the x1 column, bit 1 the z1 row.
   localparam logic [1:0] CORNER_X0Z0 = 2'b00;
   localparam logic [1:0] CORNER_X1Z0 = 2'b01;
   localparam logic [1:0] CORNER_X0Z1 = 2'b10;
   localparam logic [1:0] CORNER_X1Z1 = 2'b11;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Z,
      ST_ROW,
      ST_RD00,
      ST_RD10,
      ST_RD01,
      ST_RD11,
      ST_MAC11,
      ST_BLEND0,
      ST_BLEND1,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MA_XN1,   // x_vertices - 1
      MA_ZN1,   // z_vertices - 1
      MA_Z0,    // z cell index
      MA_RAM,   // height read from the store
      MA_R0,    // first row blend
      MA_R1     // second row blend
   } mula_type;

   typedef enum logic [2:0] {
      MB_UX,    // x offset
      MB_UZ,    // z offset
      MB_XN,    // x_vertices
      MB_WX0,   // 1 - fx
      MB_FX,
      MB_WZ0,   // 1 - fz
      MB_FZ
   } mulb_type;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic       write;
      mula_type   mul_a;
      mulb_type   mul_b;
      logic       acc_en;
      logic       acc_add;
      logic       sx_en;
      logic       sz_en;
      logic       base_en;
      logic [1:0] corner;
      logic       r0_en;
      logic       r1_en;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } dp_sts_type;

   localparam dp_cmd_type CMD_NOP = '{
      clear:    1'b0,
      load:     1'b0,
      write:    1'b0,
      mul_a:    MA_RAM,
      mul_b:    MB_FX,
      acc_en:   1'b0,
      acc_add:  1'b0,
      sx_en:    1'b0,
      sz_en:    1'b0,
      base_en:  1'b0,
      corner:   CORNER_X0Z0,
      r0_en:    1'b0,
      r1_en:    1'b0,
      out_load: 1'b0
   };

   // Saturate a vertex count to [2, maxv].
   function automatic logic [8:0] limit_count(input logic [CFG_W-1:0] v,
                                              input logic [8:0] maxv);
      logic [8:0] w;
      w = 9'(v);
      if (w < 9'd2) begin
         w = 9'd2;
      end else if (w > maxv) begin
         w = maxv;
      end
      return w;
   endfunction

endpackage

@@ src/ghbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ghbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ghbs_ctrl.sv @@
// Sequencer for the height sampler: clearing pass, item intake and the query steps.
// Depends on ghbs_pkg; drives ghbs_datapath through dp_cmd_type.
module ghbs_ctrl import ghbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NOP;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_operation == OP_QUERY) begin
                  state_in = ST_MUL_X;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_MUL_X: begin
            cmd.mul_a = MA_XN1;
            cmd.mul_b = MB_UX;
            cmd.sx_en = 1'b1;
            state_in  = ST_MUL_Z;
         end
         ST_MUL_Z: begin
            cmd.mul_a = MA_ZN1;
            cmd.mul_b = MB_UZ;
            cmd.sz_en = 1'b1;
            state_in  = ST_ROW;
         end
         ST_ROW: begin
            cmd.mul_a   = MA_Z0;
            cmd.mul_b   = MB_XN;
            cmd.base_en = 1'b1;
            state_in    = ST_RD00;
         end
         ST_RD00: begin
            cmd.corner = CORNER_X0Z0;
            state_in   = ST_RD10;
         end
         ST_RD10: begin
            cmd.corner = CORNER_X1Z0;
            cmd.mul_a  = MA_RAM;
            cmd.mul_b  = MB_WX0;
            cmd.acc_en = 1'b1;
            state_in   = ST_RD01;
         end
         ST_RD01: begin
            cmd.corner  = CORNER_X0Z1;
            cmd.mul_a   = MA_RAM;
            cmd.mul_b   = MB_FX;
            cmd.acc_en  = 1'b1;
            cmd.acc_add = 1'b1;
            state_in    = ST_RD11;
         end
         ST_RD11: begin
            cmd.corner = CORNER_X1Z1;
            cmd.r0_en  = 1'b1;
            cmd.mul_a  = MA_RAM;
            cmd.mul_b  = MB_WX0;
            cmd.acc_en = 1'b1;
            state_in   = ST_MAC11;
         end
         ST_MAC11: begin
            cmd.mul_a   = MA_RAM;
            cmd.mul_b   = MB_FX;
            cmd.acc_en  = 1'b1;
            cmd.acc_add = 1'b1;
            state_in    = ST_BLEND0;
         end
         ST_BLEND0: begin
            cmd.r1_en  = 1'b1;
            cmd.mul_a  = MA_R0;
            cmd.mul_b  = MB_WZ0;
            cmd.acc_en = 1'b1;
            state_in   = ST_BLEND1;
         end
         ST_BLEND1: begin
            cmd.mul_a   = MA_R1;
            cmd.mul_b   = MB_FZ;
            cmd.acc_en  = 1'b1;
            cmd.acc_add = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_operation == OP_QUERY) |=> state_ff == ST_MUL_X)
      else $error("query accepted but sequence did not start");

   a_write_single: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_operation == OP_WRITE) |=> state_ff == ST_IDLE)
      else $error("write word did not complete in one cycle");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !sts.out_free) |=> state_ff == ST_DONE)
      else $error("result dropped while output register full");

   a_clear_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && !sts.clear_last) |=> (state_ff == ST_CLEAR && !req_ready))
      else $error("clearing pass left early");
`endif

endmodule

@@ src/ghbs_datapath.sv @@
// Datapath for the height sampler: config registers, height store, shared MAC,
// and the output register. Depends on ghbs_pkg and ghbs_ram.
module ghbs_datapath import ghbs_pkg::*; #(
   parameter int MAX_X_VERTICES = DEF_MAX_X_VERTICES,
   parameter int MAX_Z_VERTICES = DEF_MAX_Z_VERTICES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_wdata,
   input  logic [VIDX_W-1:0]           req_vertex_index,
   input  logic [SAMPLE_W-1:0]         req_height_sample,
   input  logic signed [COORD_W-1:0]   req_query_x,
   input  logic signed [COORD_W-1:0]   req_query_z,
   input  dp_cmd_type                  cmd,
   output dp_sts_type                  sts,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [HEIGHT_W-1:0]         rsp_height_out
);

   localparam int DEPTH  = MAX_X_VERTICES * MAX_Z_VERTICES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int XN_W   = $clog2(MAX_X_VERTICES + 1);
   localparam int ZN_W   = $clog2(MAX_Z_VERTICES + 1);
   localparam logic [XN_W-1:0] XN_RESET =
      XN_W'(limit_count(CFG_W'(COUNT_RESET), 9'(MAX_X_VERTICES)));
   localparam logic [ZN_W-1:0] ZN_RESET =
      ZN_W'(limit_count(CFG_W'(COUNT_RESET), 9'(MAX_Z_VERTICES)));

   // Clamp a Q1.14 position to [-1,1] and shift it to [0,32768].
   function automatic logic [MUL_B_W-1:0] clamp_offset(input logic signed [COORD_W-1:0] v);
      logic signed [CLAMP_W-1:0] c;
      logic signed [CLAMP_W-1:0] s;
      if (v < -16'sd16384) begin
         c = -17'sd16384;
      end else if (v > 16'sd16384) begin
         c = 17'sd16384;
      end else begin
         c = CLAMP_W'(v);
      end
      s = c + 17'sd16384;
      return s[MUL_B_W-1:0];
   endfunction

   logic [XN_W-1:0]     xn_ff, xn_in;
   logic [ZN_W-1:0]     zn_ff, zn_in;
   logic [MUL_B_W-1:0]  ux_ff, ux_in, uz_ff, uz_in;
   logic [S_W-1:0]      sx_ff, sx_in, sz_ff, sz_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [ROW_W-1:0]    r0_ff, r0_in, r1_ff, r1_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [HEIGHT_W-1:0] rsp_height_ff, rsp_height_in;

   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [PROD_W-1:0]   prod;
   logic [FRAC_W-1:0]   fx, fz;
   logic [CELL_W-1:0]   x0, z0;
   logic [MUL_B_W-1:0]  wx0, wz0;
   logic [IDX_X_W-1:0]  rd_sum, idx_ext;
   logic [ACC_W-1:0]    rounded;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
   logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

   assign fx  = sx_ff[FRAC_W-1:0];
   assign fz  = sz_ff[FRAC_W-1:0];
   assign x0  = sx_ff[S_W-1:FRAC_W];
   assign z0  = sz_ff[S_W-1:FRAC_W];
   assign wx0 = ONE_Q15 - MUL_B_W'(fx);
   assign wz0 = ONE_Q15 - MUL_B_W'(fz);

   // Shared multiplier
   always_comb begin
      case (cmd.mul_a)
         MA_XN1:  mul_a = MUL_A_W'(xn_ff - XN_W'(1));
         MA_ZN1:  mul_a = MUL_A_W'(zn_ff - ZN_W'(1));
         MA_Z0:   mul_a = MUL_A_W'(z0);
         MA_RAM:  mul_a = MUL_A_W'(ram_rdata);
         MA_R0:   mul_a = MUL_A_W'(r0_ff);
         MA_R1:   mul_a = MUL_A_W'(r1_ff);
         default: mul_a = '0;
      endcase
      case (cmd.mul_b)
         MB_UX:   mul_b = ux_ff;
         MB_UZ:   mul_b = uz_ff;
         MB_XN:   mul_b = MUL_B_W'(xn_ff);
         MB_WX0:  mul_b = wx0;
         MB_FX:   mul_b = MUL_B_W'(fx);
         MB_WZ0:  mul_b = wz0;
         MB_FZ:   mul_b = MUL_B_W'(fz);
         default: mul_b = '0;
      endcase
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Corner address: row base, plus one row when z has a fraction, plus x0 or x1.
   assign rd_sum = IDX_X_W'(base_ff) + IDX_X_W'(x0)
                 + ((cmd.corner[0] && fx != '0) ? IDX_X_W'(1) : '0)
                 + ((cmd.corner[1] && fz != '0) ? IDX_X_W'(xn_ff) : '0);
   assign ram_raddr = rd_sum[ADDR_W-1:0];

   assign idx_ext = IDX_X_W'(req_vertex_index);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_cnt_ff;
      ram_wdata = '0;
      if (cmd.clear) begin
         ram_we = 1'b1;
      end else if (cmd.write && idx_ext < IDX_X_W'(DEPTH)) begin
         ram_we    = 1'b1;
         ram_waddr = idx_ext[ADDR_W-1:0];
         ram_wdata = req_height_sample;
      end
   end

   assign rounded = acc_ff + ACC_W'(1 << (ROUND_SHIFT - 1));

   always_comb begin
      xn_in         = xn_ff;
      zn_in         = zn_ff;
      ux_in         = ux_ff;
      uz_in         = uz_ff;
      sx_in         = sx_ff;
      sz_in         = sz_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      clr_cnt_in    = clr_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_height_in = rsp_height_ff;

      if (csr_wr) begin
         if (csr_index == CSR_X_VERTICES) begin
            xn_in = XN_W'(limit_count(csr_wdata, 9'(MAX_X_VERTICES)));
         end else if (csr_index == CSR_Z_VERTICES) begin
            zn_in = ZN_W'(limit_count(csr_wdata, 9'(MAX_Z_VERTICES)));
         end
      end
      if (cmd.load) begin
         ux_in = clamp_offset(req_query_x);
         uz_in = clamp_offset(req_query_z);
      end
      if (cmd.sx_en) begin
         sx_in = prod[S_W-1:0];
      end
      if (cmd.sz_en) begin
         sz_in = prod[S_W-1:0];
      end
      if (cmd.base_en) begin
         base_in = prod[ADDR_W-1:0];
      end
      if (cmd.acc_en) begin
         acc_in = cmd.acc_add ? acc_ff + prod[ACC_W-1:0] : prod[ACC_W-1:0];
      end
      if (cmd.r0_en) begin
         r0_in = acc_ff[ROW_W-1:0];
      end
      if (cmd.r1_en) begin
         r1_in = acc_ff[ROW_W-1:0];
      end
      if (cmd.clear) begin
         clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
      end
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_height_in = rounded[ROUND_SHIFT+HEIGHT_W-1:ROUND_SHIFT];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xn_ff        <= XN_RESET;
         zn_ff        <= ZN_RESET;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         xn_ff        <= xn_in;
         zn_ff        <= zn_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ux_ff         <= ux_in;
      uz_ff         <= uz_in;
      sx_ff         <= sx_in;
      sz_ff         <= sz_in;
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      r0_ff         <= r0_in;
      r1_ff         <= r1_in;
      rsp_height_ff <= rsp_height_in;
   end

   ghbs_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign sts.clear_last = (clr_cnt_ff == ADDR_W'(DEPTH - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_height_out = rsp_height_ff;

endmodule

@@ src/grid_height_bilinear_sampler_unit.sv @@
// Top level of the grid height bilinear sampler.
// Depends on ghbs_pkg, ghbs_ctrl, ghbs_datapath (which holds ghbs_ram).
//
// Usage:
//  - req_* channel (valid/ready): one word per item. req_operation selects a
//    vertex write (req_vertex_index, req_height_sample) or a height query
//    (req_query_x, req_query_z, signed Q1.14, clamped to [-1,1]).
//  - rsp_* channel (valid/ready): one word per query, rsp_height_out is the
//    bilinear blend of the four surrounding vertices, unsigned Q8.8, rounded
//    half up. Writes produce no word.
//  - csr_* port: csr_index 0 = x_vertices, 1 = z_vertices; values saturate
//    to [2, MAX]. csr_ready is always high; write only while the block is idle.
//  - Occupancy: a write leaves the block idle for the next item. A query
//    holds the block until its result is loaded; its length is set by the one
//    shared multiply-accumulate unit and the single store read port: 3 address
//    multiplies, 4 reads, 6 blend products.
//  - Reset: synchronous, active high. Afterwards a clearing pass zeroes all
//    MAX_X_VERTICES*MAX_Z_VERTICES store entries (4096 by default), one entry
//    per cycle, with req_ready low; CSR writes are taken during it.
//  - Stall: the result sits in an output register; the next item is accepted
//    meanwhile, and a following query waits at its last step until the
//    register is free.
module grid_height_bilinear_sampler_unit import ghbs_pkg::*; #(
   parameter int MAX_X_VERTICES = DEF_MAX_X_VERTICES,
   parameter int MAX_Z_VERTICES = DEF_MAX_Z_VERTICES
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_operation,
   input  logic [VIDX_W-1:0]         req_vertex_index,
   input  logic [SAMPLE_W-1:0]       req_height_sample,
   input  logic signed [COORD_W-1:0] req_query_x,
   input  logic signed [COORD_W-1:0] req_query_z,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [HEIGHT_W-1:0]       rsp_height_out,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CFG_W-1:0]          csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // CSR writes never stall
   assign csr_ready = 1'b1;

   ghbs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd)
   );

   ghbs_datapath #(
      .MAX_X_VERTICES (MAX_X_VERTICES),
      .MAX_Z_VERTICES (MAX_Z_VERTICES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_vertex_index  (req_vertex_index),
      .req_height_sample (req_height_sample),
      .req_query_x       (req_query_x),
      .req_query_z       (req_query_z),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_height_out    (rsp_height_out)
   );

endmodule

@@ verif/tb_grid_height_bilinear_sampler_unit.sv @@
// Self-checking testbench for grid_height_bilinear_sampler_unit.
// Depends on ghbs_pkg and the block's RTL. A scoreboard class predicts each
// query's Q8.8 height from its own copy of the vertex grid and grid size.
module tb_grid_height_bilinear_sampler_unit import ghbs_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_X       = DEF_MAX_X_VERTICES;
   localparam int MAX_Z       = DEF_MAX_Z_VERTICES;
   localparam int STORE_DEPTH = MAX_X * MAX_Z;
   localparam int ONE_Q14     = 16384;
   localparam longint unsigned ONE_W = 32768;   // 1.0 as a Q0.15 weight
   localparam int SETTLE      = 16;
   localparam int CYCLE_LIMIT = 400000;  // covers the clear pass plus stalled items
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 155;

   // index the block decodes to nothing; writes to it must change no setting
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // Scoreboard: shadow grid, shadow grid size and the heights still owed.
   class grid_height_tracker;
      logic [SAMPLE_W-1:0] heights [STORE_DEPTH];
      int unsigned         x_count;
      int unsigned         z_count;
      logic [HEIGHT_W-1:0] heights_due [$];
      int                  mismatches;
      int                  checked;
      int                  queries;

      function new();
         foreach (heights[i]) heights[i] = '0;
         x_count    = COUNT_RESET;
         z_count    = COUNT_RESET;
         mismatches = 0;
         checked    = 0;
         queries    = 0;
      endfunction

      function int unsigned saturate(logic [CFG_W-1:0] v, int unsigned maxv);
         if (v < 2) return 2;
         if (v > maxv) return maxv;
         return v;
      endfunction

      function void note_config(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         if (idx == CSR_X_VERTICES) begin
            x_count = saturate(data, MAX_X);
         end else if (idx == CSR_Z_VERTICES) begin
            z_count = saturate(data, MAX_Z);
         end
      endfunction

      // Q1.14 position clamped to [-1,1], returned as offset in [0,32768]
      function int unsigned offset_of(logic signed [COORD_W-1:0] c);
         int v;
         v = c;
         if (v < -ONE_Q14) v = -ONE_Q14;
         if (v > ONE_Q14) v = ONE_Q14;
         return v + ONE_Q14;
      endfunction

      function longint unsigned vertex_at(int unsigned xi, int unsigned zi);
         int unsigned a;
         a = zi * x_count + xi;
         if (a >= STORE_DEPTH) return 0;
         return heights[a];
      endfunction

      function logic [HEIGHT_W-1:0] blend_height(logic signed [COORD_W-1:0] qx,
                                                 logic signed [COORD_W-1:0] qz);
         int unsigned     sx, sz, x0, z0, x1, z1, fx, fz;
         longint unsigned r0, r1, mix;
         sx = (x_count - 1) * offset_of(qx);
         sz = (z_count - 1) * offset_of(qz);
         x0 = sx >> FRAC_W;
         z0 = sz >> FRAC_W;
         fx = sx & 32'h7FFF;
         fz = sz & 32'h7FFF;
         // on an exact grid hit the far neighbor is never touched
         x1 = (fx != 0) ? x0 + 1 : x0;
         z1 = (fz != 0) ? z0 + 1 : z0;
         r0 = vertex_at(x0, z0) * (ONE_W - fx) + vertex_at(x1, z0) * fx;
         r1 = vertex_at(x0, z1) * (ONE_W - fx) + vertex_at(x1, z1) * fx;
         mix = r0 * (ONE_W - fz) + r1 * fz;   // Q8.30
         return HEIGHT_W'((mix + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT);
      endfunction

      function void note_input(logic op, logic [VIDX_W-1:0] vidx,
                               logic [SAMPLE_W-1:0] smp,
                               logic signed [COORD_W-1:0] qx,
                               logic signed [COORD_W-1:0] qz);
         if (op == OP_WRITE) begin
            heights[vidx] = smp;
         end else begin
            heights_due.insert(heights_due.size(), blend_height(qx, qz));
            queries++;
         end
      endfunction

      function void check_result(logic [HEIGHT_W-1:0] h);
         logic [HEIGHT_W-1:0] want;
         checked++;
         if (heights_due.size() == 0) begin
            $error("height_out word %0d arrived with no query outstanding", h);
            mismatches++;
            return;
         end
         want = heights_due.pop_front();
         if (h !== want) begin
            $error("height_out mismatch: expected %0d, actual %0d", want, h);
            mismatches++;
         end
      endfunction

      function int pending();
         return heights_due.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_operation;
   logic [VIDX_W-1:0]         req_vertex_index;
   logic [SAMPLE_W-1:0]       req_height_sample;
   logic signed [COORD_W-1:0] req_query_x;
   logic signed [COORD_W-1:0] req_query_z;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [HEIGHT_W-1:0]       rsp_height_out;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CFG_W-1:0]          csr_wdata;

   grid_height_tracker tracker;
   int send_idle;     // percent of cycles the sender holds back
   int take_idle;     // percent of cycles the receiver stalls
   int words_sent;
   int grid_settings;
   int cycles = 0;

   // Raw grid sizes per phase; out-of-range values exercise saturation.
   int phase_x [PHASES] = '{127, 2, 3, 1, 17, 64};
   int phase_z [PHASES] = '{0, 64, 5, 127, 33, 64};

   grid_height_bilinear_sampler_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_vertex_index  (req_vertex_index),
      .req_height_sample (req_height_sample),
      .req_query_x       (req_query_x),
      .req_query_z       (req_query_z),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_height_out    (rsp_height_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: check each accepted word, then pick next cycle's ready.
   // Values are sampled at the edge, before this step's updates land.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            tracker.check_result(rsp_height_out);
         end
         rsp_ready <= ($urandom_range(99) >= take_idle);
      end
   end

   // One request word. Valid is only dropped for an idle gap, never between
   // back-to-back words, so it gets one update per time step.
   task automatic send_word(input logic op, input logic [VIDX_W-1:0] vidx,
                            input logic [SAMPLE_W-1:0] smp,
                            input logic signed [COORD_W-1:0] qx,
                            input logic signed [COORD_W-1:0] qz);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_vertex_index  <= vidx;
      req_height_sample <= smp;
      req_query_x       <= qx;
      req_query_z       <= qz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_input(op, vidx, smp, qx, qz);
      words_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.note_config(idx, data);
   endtask

   // New grid size; optionally a write to the undecoded index as noise.
   task automatic set_grid(input logic [CFG_W-1:0] xraw, input logic [CFG_W-1:0] zraw,
                           input bit noise);
      write_reg(CSR_X_VERTICES, xraw);
      if (noise) write_reg(CSR_SPARE, CFG_W'($urandom));
      write_reg(CSR_Z_VERTICES, zraw);
      csr_valid <= 1'b0;
      grid_settings++;
   endtask

   // Stop sending, let every owed height come back, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Query coordinate: mostly inside the grid, some beyond the edge, some
   // landing on vertex lines, some at the clamp boundaries.
   function automatic logic signed [COORD_W-1:0] pick_coord(int unsigned n);
      int unsigned k;
      int          r;
      r = $urandom_range(99);
      if (r < 50) return COORD_W'(int'($urandom_range(32768)) - ONE_Q14);
      if (r < 70) return COORD_W'($urandom);
      if (r < 85) begin
         k = $urandom_range(n - 1);
         return COORD_W'(int'((k * 32768) / (n - 1)) - ONE_Q14);
      end
      case ($urandom_range(4))
         0: return -16'sd16384;
         1: return 16'sd16384;
         2: return 16'sh8000;
         3: return 16'sh7FFF;
         default: return '0;
      endcase
   endfunction

   task automatic send_random(input int count);
      logic                      op;
      logic [VIDX_W-1:0]         vidx;
      logic [SAMPLE_W-1:0]       smp;
      logic signed [COORD_W-1:0] qx;
      logic signed [COORD_W-1:0] qz;
      repeat (count) begin
         op   = ($urandom_range(99) < 40) ? OP_WRITE : OP_QUERY;
         // unused fields stay random: the block must ignore them
         vidx = VIDX_W'($urandom);
         smp  = SAMPLE_W'($urandom);
         qx   = COORD_W'($urandom);
         qz   = COORD_W'($urandom);
         if (op == OP_WRITE) begin
            // mostly land inside the active grid so queries see the data
            if ($urandom_range(99) < 80) begin
               vidx = VIDX_W'($urandom_range(tracker.z_count - 1) * tracker.x_count
                              + $urandom_range(tracker.x_count - 1));
            end
            if ($urandom_range(99) < 15) smp = $urandom_range(1) ? 8'hFF : 8'h00;
         end else begin
            qx = pick_coord(tracker.x_count);
            qz = pick_coord(tracker.z_count);
         end
         send_word(op, vidx, smp, qx, qz);
      end
   endtask

   initial begin
      tracker           = new();
      words_sent        = 0;
      grid_settings     = 0;
      send_idle         = 24;
      take_idle         = 71;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_operation     <= OP_WRITE;
      req_vertex_index  <= '0;
      req_height_sample <= '0;
      req_query_x       <= '0;
      req_query_z       <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= CSR_X_VERTICES;
      csr_wdata         <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed words on the reset 64x64 grid. The clear pass runs first;
      // send_word simply waits for ready.
      send_word(OP_QUERY, 12'hFFF, 8'hFF, 16'sd0, 16'sd0);        // flat grid
      send_word(OP_WRITE, 12'd0, 8'hFF, 16'sh7FFF, 16'sh8000);    // query fields ignored
      send_word(OP_WRITE, 12'hFFF, 8'hFF, 16'sd0, 16'sd0);
      send_word(OP_WRITE, 12'd63, 8'd128, 16'sd0, 16'sd0);
      send_word(OP_WRITE, 12'd4032, 8'd1, 16'sd0, 16'sd0);
      // cell around the grid center, fraction one half on both axes
      send_word(OP_WRITE, 12'd2015, 8'd200, 16'sd0, 16'sd0);
      send_word(OP_WRITE, 12'd2016, 8'd10, 16'sd0, 16'sd0);
      send_word(OP_WRITE, 12'd2079, 8'd255, 16'sd0, 16'sd0);
      send_word(OP_WRITE, 12'd2080, 8'd77, 16'sd0, 16'sd0);
      // corners and the center, with write fields set that must be ignored
      send_word(OP_QUERY, 12'hFFF, 8'hFF, 16'sh8000, 16'sh8000);
      send_word(OP_QUERY, 12'd0, 8'd0, 16'sh7FFF, 16'sh7FFF);
      send_word(OP_QUERY, 12'd5, 8'd9, 16'sd16384, -16'sd16384);
      send_word(OP_QUERY, 12'd5, 8'd9, -16'sd16384, 16'sd16384);
      send_word(OP_QUERY, 12'd0, 8'd0, 16'sd0, 16'sd0);
      // just past the edges: must saturate
      send_word(OP_QUERY, 12'd0, 8'd0, -16'sd16385, 16'sd16385);
      send_word(OP_QUERY, 12'd0, 8'd0, -16'sd1, 16'sd1);
      send_word(OP_WRITE, 12'd0, 8'd0, 16'sd0, 16'sd0);
      send_word(OP_QUERY, 12'd0, 8'd0, -16'sd16384, -16'sd16384);
      drain();

      // Random phases: sender light / receiver heavy idling, then swapped,
      // then full rate both ways.
      for (int p = 0; p < PHASES; p++) begin
         send_idle = (p < 2) ? 24 : (p < 4) ? 71 : 0;
         take_idle = (p < 2) ? 71 : (p < 4) ? 24 : 0;
         set_grid(CFG_W'(phase_x[p]), CFG_W'(phase_z[p]), (p == 2) || (p == 4));
         send_random(PHASE_ITEMS);
         drain();
      end

      $display("%0d words sent (%0d queries), %0d heights compared over %0d grid sizes",
               words_sent, tracker.queries, tracker.checked, grid_settings);
      if (tracker.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
